// ===== hdl/pidaw_pkg.sv =====
// Package for the discrete PID controller with anti-windup.
// Holds the fixed-point widths, the register map, the sequencer states and the
// saturation helpers. Depends on nothing else.
package pidaw_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int TS_WIDTH        = DATA_WIDTH - 1;
    localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
    localparam int MAG_WIDTH       = PROD_WIDTH - FRAC_BITS;
    localparam int DIV_STEPS       = DATA_WIDTH + 1;
    localparam int DIV_PRE         = DIV_STEPS - FRAC_BITS;
    localparam int CNT_WIDTH       = $clog2(DIV_STEPS);
    localparam int IN_TDATA_WIDTH  = 2 * DATA_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((DATA_WIDTH + 1 + 7) / 8) * 8;
    localparam int ADDR_WIDTH      = 5;
    localparam int APB_WIDTH       = 32;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic        [MAG_WIDTH-1:0]  t_mag;

    localparam t_data SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_TS,
        REG_UP,
        REG_LO,
        REG_AW
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_DM,
        ST_SUM,
        ST_MUL_P,
        ST_FIN_P,
        ST_MUL_I,
        ST_FIN_I,
        ST_MUL_T,
        ST_FIN_T,
        ST_INTEG,
        ST_MUL_D,
        ST_FIN_D,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_PI,
        ST_PID,
        ST_OUT
    } t_state;

    // Saturate a sum or difference that carries one guard bit.
    function automatic t_data sat_wide(input logic [DATA_WIDTH:0] v);
        if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
            return v[DATA_WIDTH] ? SMIN : SMAX;
        end
        return t_data'(v[DATA_WIDTH-1:0]);
    endfunction

    // Apply a sign to a magnitude and saturate to the data width.
    function automatic t_data sat_mag(input t_mag m, input logic neg);
        t_mag lim;
        lim = t_mag'(1) << (DATA_WIDTH - 1);
        if (neg) begin
            if (m > lim) begin
                return SMIN;
            end
            return t_data'(DATA_WIDTH'(0) - m[DATA_WIDTH-1:0]);
        end
        if (m >= lim) begin
            return SMAX;
        end
        return t_data'(m[DATA_WIDTH-1:0]);
    endfunction

    // Magnitude of a signed value; the most negative value maps to 2^(N-1).
    function automatic logic [DATA_WIDTH-1:0] mag_of(input t_data v);
        logic [DATA_WIDTH-1:0] u;
        u = v;
        return u[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - u) : u;
    endfunction

endpackage

// ===== hdl/pid_controller_anti_windup_top.sv =====
// Each accepted input word is worked through the sequencer into the output register; the divider
// steps are skipped when the derivative numerator is zero or its quotient saturates. A new word
// is taken only in idle, once the previous one is done. The datapath has a 33-step serial divider
// and a single shared 32x32 multiplier, which the sequencer uses four times per sample.
// Reset (synchronous, active low) clears the integrator, the previous error and measurement,
// the indicator and the output valid, and loads the register reset values.
module pid_controller_anti_windup_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [31:0] measured_value, [63:32] target_value
    input  logic [pidaw_pkg::IN_TDATA_WIDTH-1:0]   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [31:0] drive_value, [32] windup_indicator, [39:33] zero
    output logic [pidaw_pkg::OUT_TDATA_WIDTH-1:0]  o_m_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pidaw_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [pidaw_pkg::APB_WIDTH-1:0]        pwdata,
    output logic [pidaw_pkg::APB_WIDTH-1:0]        prdata,
    output logic                                   pready
);
    import pidaw_pkg::*;

    // Configuration registers
    t_data                r_kp, r_ki, r_kd, r_up, r_lo;
    logic [TS_WIDTH-1:0]  r_ts;
    logic                 r_aw;

    // Controller state
    t_data                r_integ, r_last_err, r_last_meas;
    logic                 r_ind;

    // Sequencer and datapath
    t_state               r_state, n_state;
    t_data                r_meas, r_tgt, r_err, r_dm, r_s, r_p, r_mres, r_d, r_ctrl;
    logic [PROD_WIDTH-1:0] r_prod;
    logic                 r_neg;
    logic [TS_WIDTH-1:0]  r_rem;
    logic [DIV_STEPS-1:0] r_dq;
    logic [CNT_WIDTH-1:0] r_cnt;
    logic                 r_dneg;
    logic                 r_out_valid;
    logic [OUT_TDATA_WIDTH-1:0] r_out_data;

    t_reg                 reg_idx;
    logic                 cfg_wr;
    t_data                alu_a, alu_b, alu_res;
    logic                 alu_sub;
    logic [DATA_WIDTH:0]  alu_wide;
    logic [DATA_WIDTH-1:0] mul_a, mul_b;
    logic                 mul_neg;
    logic [PROD_WIDTH-1:0] mul_prod;
    t_data                mul_res;
    logic [DATA_WIDTH-1:0] div_mag;
    logic                 div_zero, div_ovf;
    logic [TS_WIDTH:0]    div_trial, div_diff;
    logic                 div_ge;
    logic                 in_acc, out_load;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg'(paddr[ADDR_WIDTH-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
            r_ts <= TS_WIDTH'(1) << FRAC_BITS;
            r_up <= SMAX;
            r_lo <= SMIN;
            r_aw <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KP: r_kp <= t_data'(pwdata[DATA_WIDTH-1:0]);
                REG_KI: r_ki <= t_data'(pwdata[DATA_WIDTH-1:0]);
                REG_KD: r_kd <= t_data'(pwdata[DATA_WIDTH-1:0]);
                REG_TS: r_ts <= pwdata[TS_WIDTH-1:0];
                REG_UP: r_up <= t_data'(pwdata[DATA_WIDTH-1:0]);
                REG_LO: r_lo <= t_data'(pwdata[DATA_WIDTH-1:0]);
                REG_AW: r_aw <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KP:  prdata = APB_WIDTH'(unsigned'(r_kp));
            REG_KI:  prdata = APB_WIDTH'(unsigned'(r_ki));
            REG_KD:  prdata = APB_WIDTH'(unsigned'(r_kd));
            REG_TS:  prdata = APB_WIDTH'(r_ts);
            REG_UP:  prdata = APB_WIDTH'(unsigned'(r_up));
            REG_LO:  prdata = APB_WIDTH'(unsigned'(r_lo));
            REG_AW:  prdata = APB_WIDTH'(r_aw);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared units: one saturating adder, one multiplier, one divider step
    // ------------------------------------------------------------------
    assign alu_wide = alu_sub ? ({alu_a[DATA_WIDTH-1], alu_a} - {alu_b[DATA_WIDTH-1], alu_b})
                              : ({alu_a[DATA_WIDTH-1], alu_a} + {alu_b[DATA_WIDTH-1], alu_b});
    assign alu_res  = sat_wide(alu_wide);

    assign mul_prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
    // The product is a magnitude; dropping the fraction bits truncates toward zero.
    assign mul_res  = sat_mag(r_prod[PROD_WIDTH-1:FRAC_BITS], r_neg);

    // Quotient bits above the divider width (one more than the data width) would saturate anyway,
    // so they are detected up front and the divider produces only the lower bits.
    assign div_mag   = mag_of(r_mres);
    assign div_zero  = (r_mres == '0);
    assign div_ovf   = ((div_mag >> DIV_PRE) >= DATA_WIDTH'(r_ts));
    assign div_trial = {r_rem, r_dq[DIV_STEPS-1]};
    assign div_diff  = div_trial - {1'b0, r_ts};
    assign div_ge    = (div_trial >= {1'b0, r_ts});

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_tready);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_s_tvalid) n_state = ST_ERR;
            ST_ERR:      n_state = ST_DM;
            ST_DM:       n_state = ST_SUM;
            ST_SUM:      n_state = ST_MUL_P;
            ST_MUL_P:    n_state = ST_FIN_P;
            ST_FIN_P:    n_state = ST_MUL_I;
            ST_MUL_I:    n_state = ST_FIN_I;
            ST_FIN_I:    n_state = ST_MUL_T;
            ST_MUL_T:    n_state = ST_FIN_T;
            ST_FIN_T:    n_state = ST_INTEG;
            ST_INTEG:    n_state = ST_MUL_D;
            ST_MUL_D:    n_state = ST_FIN_D;
            ST_FIN_D:    n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = (div_zero || div_ovf) ? ST_PI : ST_DIV;
            ST_DIV:      if (r_cnt == '0) n_state = ST_DIV_FIN;
            ST_DIV_FIN:  n_state = ST_PI;
            ST_PI:       n_state = ST_PID;
            ST_PID:      n_state = ST_OUT;
            ST_OUT:      if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: operand selection for the shared units
    // ------------------------------------------------------------------
    always_comb begin
        alu_a   = r_tgt;
        alu_b   = r_meas;
        alu_sub = 1'b1;
        mul_a   = mag_of(r_kp);
        mul_b   = mag_of(r_err);
        mul_neg = r_kp[DATA_WIDTH-1] ^ r_err[DATA_WIDTH-1];
        unique case (r_state)
            ST_DM: begin
                alu_a = r_meas;
                alu_b = r_last_meas;
            end
            ST_SUM: begin
                alu_a   = r_err;
                alu_b   = r_last_err;
                alu_sub = 1'b0;
            end
            ST_INTEG: begin
                alu_a   = r_integ;
                alu_b   = r_mres;
                alu_sub = 1'b0;
            end
            ST_PI: begin
                alu_a   = r_p;
                alu_b   = r_integ;
                alu_sub = 1'b0;
            end
            ST_PID: begin
                alu_a   = r_ctrl;
                alu_b   = r_d;
                alu_sub = 1'b0;
            end
            ST_MUL_I: begin
                mul_a   = mag_of(r_ki);
                mul_b   = mag_of(r_s);
                mul_neg = r_ki[DATA_WIDTH-1] ^ r_s[DATA_WIDTH-1];
            end
            ST_MUL_T: begin
                // The sample period is never negative.
                mul_a   = DATA_WIDTH'(r_ts);
                mul_b   = mag_of(r_mres);
                mul_neg = r_mres[DATA_WIDTH-1];
            end
            ST_MUL_D: begin
                mul_a   = mag_of(r_kd);
                mul_b   = mag_of(r_dm);
                mul_neg = r_kd[DATA_WIDTH-1] ^ r_dm[DATA_WIDTH-1];
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_last_meas <= '0;
            r_ind       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DM) begin
                r_last_meas <= r_meas;
            end
            if (r_state == ST_SUM) begin
                r_last_err <= r_err;
            end
            if (r_state == ST_INTEG) begin
                if (!r_aw) begin
                    r_integ <= alu_res;
                end else if (alu_res <= r_up) begin
                    r_integ <= alu_res;
                    r_ind   <= 1'b1;
                end else begin
                    r_integ <= '0;
                    r_ind   <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_meas <= t_data'(i_s_tdata[DATA_WIDTH-1:0]);
                    r_tgt  <= t_data'(i_s_tdata[IN_TDATA_WIDTH-1:DATA_WIDTH]);
                end
            end
            ST_ERR: r_err <= alu_res;
            ST_DM:  r_dm  <= alu_res;
            ST_SUM: r_s   <= alu_res;
            ST_MUL_P, ST_MUL_I, ST_MUL_T, ST_MUL_D: begin
                r_prod <= mul_prod;
                r_neg  <= mul_neg;
            end
            ST_FIN_P: r_p <= mul_res;
            ST_FIN_I, ST_FIN_T, ST_FIN_D: r_mres <= mul_res;
            ST_DIV_INIT: begin
                r_dneg <= r_mres[DATA_WIDTH-1];
                r_rem  <= TS_WIDTH'(div_mag >> DIV_PRE);
                r_dq   <= {div_mag[DIV_PRE-1:0], {FRAC_BITS{1'b0}}};
                r_cnt  <= CNT_WIDTH'(DIV_STEPS - 1);
                if (div_zero) begin
                    r_d <= '0;
                end else if (div_ovf) begin
                    // Also covers a zero sample period.
                    r_d <= r_mres[DATA_WIDTH-1] ? SMIN : SMAX;
                end
            end
            ST_DIV: begin
                r_rem <= div_ge ? div_diff[TS_WIDTH-1:0] : div_trial[TS_WIDTH-1:0];
                r_dq  <= {r_dq[DIV_STEPS-2:0], div_ge};
                r_cnt <= r_cnt - CNT_WIDTH'(1);
            end
            ST_DIV_FIN: r_d <= sat_mag(MAG_WIDTH'(r_dq), r_dneg);
            ST_PI:      r_ctrl <= alu_res;
            ST_PID: begin
                // With crossed limits the upper limit is checked first and wins for values above it.
                if (alu_res > r_up) begin
                    r_ctrl <= r_up;
                end else if (alu_res < r_lo) begin
                    r_ctrl <= r_lo;
                end else begin
                    r_ctrl <= alu_res;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    r_out_data <= {{(OUT_TDATA_WIDTH-DATA_WIDTH-1){1'b0}}, r_ind, r_ctrl};
                end
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/pidaw_chk.sv =====
// Port-level checker for the PID controller top level, attached by bind.
// Depends on pidaw_pkg for the port widths.
module pidaw_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_tvalid,
    input logic                                   o_s_tready,
    input logic [pidaw_pkg::IN_TDATA_WIDTH-1:0]   i_s_tdata,
    input logic                                   o_m_tvalid,
    input logic                                   i_m_tready,
    input logic [pidaw_pkg::OUT_TDATA_WIDTH-1:0]  o_m_tdata,
    input logic                                   psel,
    input logic                                   penable,
    input logic                                   pwrite,
    input logic [pidaw_pkg::ADDR_WIDTH-1:0]       paddr,
    input logic [pidaw_pkg::APB_WIDTH-1:0]        pwdata,
    input logic [pidaw_pkg::APB_WIDTH-1:0]        prdata,
    input logic                                   pready
);
    import pidaw_pkg::*;

    // A result word that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // One sample is processed at a time: taking a word closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a word was taken");

    // The input does not reopen early: it is still closed partway through the sequence.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> ##8 !o_s_tready)
        else $error("input reopened too early");

    // Pad bits above the indicator are zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_TDATA_WIDTH-1:DATA_WIDTH+1] == '0)
        else $error("nonzero pad bits in output word");

endmodule

bind pid_controller_anti_windup_top pidaw_chk u_pidaw_chk (.*);

// ===== tb/pid_controller_anti_windup_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pid_controller_anti_windup_top: directed table, then random phases.
// Each accepted sample is run through a fixed-point PID predictor; that result, or a typed value from the
// directed table, is compared on the output. Depends on pidaw_pkg and the top level only.
module pid_controller_anti_windup_top_tb;

    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;
    localparam int     STALL_LIMIT = 20000;
    localparam int     FB          = pidaw_pkg::FRAC_BITS;

    typedef struct packed {
        logic [31:0] drive;
        logic        windup;
    } t_drive_out;

    typedef struct {
        bit               is_reg;
        pidaw_pkg::t_reg  reg_id;
        logic [31:0]      a;
        logic [31:0]      b;
        bit               typed;
        t_drive_out       typed_out;
    } t_row;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [pidaw_pkg::IN_TDATA_WIDTH-1:0]  s_tdata;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [pidaw_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [pidaw_pkg::ADDR_WIDTH-1:0]      paddr;
    logic [pidaw_pkg::APB_WIDTH-1:0]       pwdata;
    logic [pidaw_pkg::APB_WIDTH-1:0]       prdata;
    logic                                  pready;

    // Register mirror and controller state of the predictor.
    longint kp_g, ki_g, kd_g, up_lim, lo_lim, ts_q;
    bit     aw_on;
    longint integ_acc, prev_err, prev_meas;
    bit     ind_bit;

    t_drive_out drive_forecast[$];
    t_row       directed_rows[$];
    bit         typed_on;
    t_drive_out typed_val;
    int         mismatch_count;
    int         src_gap_pct;
    int         sink_gap_pct;
    int         hold_req;
    int         hold_left;
    int         quiet_cycles;

    pid_controller_anti_windup_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint unsigned abs_u(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint apply_sign(input longint unsigned m, input bit neg);
        if (neg) begin
            return (m > 64'd2147483648) ? WORD_MIN : -longint'(m);
        end
        return (m > 64'd2147483647) ? WORD_MAX : longint'(m);
    endfunction

    // Products truncate toward zero on the magnitude, then saturate.
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned p;
        p = abs_u(a) * abs_u(b);
        return apply_sign(p >> FB, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(input longint num, input longint unsigned d);
        if (num == 0) return 0;
        if (d == 0) return (num < 0) ? WORD_MIN : WORD_MAX;
        return apply_sign((abs_u(num) << FB) / d, num < 0);
    endfunction

    function automatic t_drive_out pid_sample_response(input logic [31:0] meas_w,
                                                       input logic [31:0] tgt_w);
        longint     meas, err, p, inc, d, ctrl;
        t_drive_out r;
        meas = longint'($signed(meas_w));
        err  = clamp_word(longint'($signed(tgt_w)) - meas);
        p    = fx_mul(kp_g, err);
        inc  = fx_mul(ts_q, fx_mul(ki_g, clamp_word(err + prev_err)));
        integ_acc = clamp_word(integ_acc + inc);
        if (aw_on) begin
            if (integ_acc <= up_lim) begin
                ind_bit = 1'b1;
            end else begin
                integ_acc = 0;
                ind_bit   = 1'b0;
            end
        end
        d    = fx_div(fx_mul(kd_g, clamp_word(meas - prev_meas)), ts_q);
        ctrl = clamp_word(clamp_word(p + integ_acc) + d);
        // With crossed limits the upper one is checked first and wins for values above it.
        if (ctrl > up_lim) begin
            ctrl = up_lim;
        end else if (ctrl < lo_lim) begin
            ctrl = lo_lim;
        end
        prev_meas = meas;
        prev_err  = err;
        r.drive  = ctrl[31:0];
        r.windup = ind_bit;
        return r;
    endfunction

    // Sampling happens at the rising edge, before the block's registers update.
    always @(posedge i_clk) begin : monitor
        t_drive_out pred;
        t_drive_out want;
        bit         moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                pred  = pid_sample_response(s_tdata[31:0], s_tdata[63:32]);
                drive_forecast.push_back(typed_on ? typed_val : pred);
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (drive_forecast.size() == 0) begin
                    $display("%0t: output word with nothing expected, got %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = drive_forecast.pop_front();
                    if (m_tdata[31:0] !== want.drive) begin
                        $display("%0t: drive_value expected %h got %h",
                                 $time, want.drive, m_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[32] !== want.windup) begin
                        $display("%0t: windup_indicator expected %b got %b",
                                 $time, want.windup, m_tdata[32]);
                        mismatch_count++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("pid_controller_anti_windup_top_tb: errors");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (drive_forecast.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input pidaw_pkg::t_reg r, input logic [31:0] v);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            pidaw_pkg::REG_KP: kp_g   = longint'($signed(v));
            pidaw_pkg::REG_KI: ki_g   = longint'($signed(v));
            pidaw_pkg::REG_KD: kd_g   = longint'($signed(v));
            pidaw_pkg::REG_TS: ts_q   = longint'(v[30:0]);
            pidaw_pkg::REG_UP: up_lim = longint'($signed(v));
            pidaw_pkg::REG_LO: lo_lim = longint'($signed(v));
            default:           aw_on  = v[0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic offer_sample(input logic [31:0] meas, input logic [31:0] tgt);
        @(negedge i_clk);
        while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt, meas};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic add_reg(input pidaw_pkg::t_reg r, input logic [31:0] v);
        t_row row;
        row = '{1'b1, r, v, 32'd0, 1'b0, '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_sample(input logic [31:0] m, input logic [31:0] t);
        t_row row;
        row = '{1'b0, pidaw_pkg::REG_KP, m, t, 1'b0, '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [31:0] m, input logic [31:0] t,
                             input logic [31:0] drv, input logic ind);
        t_row row;
        row = '{1'b0, pidaw_pkg::REG_KP, m, t, 1'b1, '{drv, ind}};
        directed_rows.push_back(row);
    endtask

    function automatic logic [31:0] small_signed(input int unsigned span);
        logic [31:0] v;
        v = $urandom_range(0, span);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom;
            default: return small_signed(32'h4_0000);
        endcase
    endfunction

    task automatic run_random_phase(input int n);
        logic [31:0] base, meas, tgt, ts_v, up_v, lo_v;
        case ($urandom_range(0, 4))
            0:       ts_v = 32'h0;
            1:       ts_v = 32'h1;
            2:       ts_v = 32'h7FFF_FFFF;
            3:       ts_v = 32'h1_0000;
            default: ts_v = $urandom_range(1, 32'h4_0000);
        endcase
        case ($urandom_range(0, 5))
            0: begin
                up_v = 32'h7FFF_FFFF;
                lo_v = 32'h8000_0000;
            end
            1: begin
                up_v = -$urandom_range(0, 32'h20_0000);
                lo_v = $urandom_range(1, 32'h20_0000);
            end
            2: begin
                up_v = $urandom;
                lo_v = $urandom;
            end
            default: begin
                up_v = $urandom_range(1, 32'h40_0000);
                lo_v = -$urandom_range(1, 32'h40_0000);
            end
        endcase
        write_reg(pidaw_pkg::REG_KP, pick_gain());
        write_reg(pidaw_pkg::REG_KI, pick_gain());
        write_reg(pidaw_pkg::REG_KD, pick_gain());
        write_reg(pidaw_pkg::REG_TS, ts_v);
        write_reg(pidaw_pkg::REG_UP, up_v);
        write_reg(pidaw_pkg::REG_LO, lo_v);
        write_reg(pidaw_pkg::REG_AW, $urandom_range(0, 1));
        base = small_signed(32'h10_0000);
        repeat (n) begin
            // Mostly a set point held for a while with the measurement close by, so the
            // integrator builds up toward the limits; now and then noise or extremes.
            if ($urandom_range(0, 29) == 0) begin
                base = small_signed(32'h10_0000);
            end
            case ($urandom_range(0, 15))
                0: begin
                    meas = $urandom;
                    tgt  = $urandom;
                end
                1: begin
                    meas = pick_extreme();
                    tgt  = pick_extreme();
                end
                default: begin
                    tgt  = base + small_signed(32'h400);
                    meas = tgt - small_signed(32'h4_0000);
                end
            endcase
            offer_sample(meas, tgt);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        kp_g           = 0;
        ki_g           = 0;
        kd_g           = 0;
        ts_q           = 65536;
        up_lim         = WORD_MAX;
        lo_lim         = WORD_MIN;
        aw_on          = 1'b0;
        integ_acc      = 0;
        prev_err       = 0;
        prev_meas      = 0;
        ind_bit        = 1'b0;
        typed_on       = 1'b0;
        typed_val      = '0;
        mismatch_count = 0;
        hold_req       = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        src_gap_pct    = 17;
        sink_gap_pct   = 49;

        // Zero gains after reset give a zero drive whatever the error.
        add_typed(32'h0, 32'h0, 32'h0, 1'b0);
        add_typed(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        add_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
        add_reg(pidaw_pkg::REG_KP, 32'h0001_0000);
        add_typed(32'h0, 32'h0005_0000, 32'h0005_0000, 1'b0);
        add_reg(pidaw_pkg::REG_KP, 32'h7FFF_FFFF);
        add_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_reg(pidaw_pkg::REG_KP, 32'h8000_0000);
        add_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        // Integrator climbing past the upper limit with anti-windup on, then off.
        add_reg(pidaw_pkg::REG_KP, 32'h0);
        add_reg(pidaw_pkg::REG_KI, 32'h0001_0000);
        add_reg(pidaw_pkg::REG_UP, 32'h000A_0000);
        add_reg(pidaw_pkg::REG_LO, 32'hFFF6_0000);
        add_reg(pidaw_pkg::REG_AW, 32'h1);
        repeat (5) add_sample(32'h0, 32'h0002_0000);
        add_reg(pidaw_pkg::REG_AW, 32'h0);
        repeat (2) add_sample(32'h0, 32'h0002_0000);
        // Derivative with zero, smallest and largest sample period; a zero one saturates by numerator sign.
        add_reg(pidaw_pkg::REG_KI, 32'h0);
        add_reg(pidaw_pkg::REG_KD, 32'h0001_0000);
        add_reg(pidaw_pkg::REG_TS, 32'h0);
        add_sample(32'h0001_0000, 32'h0);
        add_sample(32'h0001_0000, 32'h0);
        add_sample(32'hFFFF_0000, 32'h0);
        add_reg(pidaw_pkg::REG_TS, 32'h1);
        add_sample(32'h0003_0000, 32'h0);
        add_reg(pidaw_pkg::REG_TS, 32'h7FFF_FFFF);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF);
        // Crossed limits.
        add_reg(pidaw_pkg::REG_UP, 32'hFFFB_0000);
        add_reg(pidaw_pkg::REG_LO, 32'h0005_0000);
        add_sample(32'h0, 32'h0);
        add_sample(32'h0, 32'h0001_0000);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_reg) begin
                write_reg(directed_rows[k].reg_id, directed_rows[k].a);
            end else begin
                // Switch the expected value away from the accepting edge of the previous word.
                @(negedge i_clk);
                typed_on  = directed_rows[k].typed;
                typed_val = directed_rows[k].typed_out;
                offer_sample(directed_rows[k].a, directed_rows[k].b);
            end
        end
        typed_on = 1'b0;

        for (int ph = 0; ph < 9; ph++) begin
            src_gap_pct  = (ph < 3) ? 17 : (ph < 6) ? 49 : 0;
            sink_gap_pct = (ph < 3) ? 49 : (ph < 6) ? 17 : 0;
            if (ph == 1 || ph == 7) begin
                hold_req = 300;
            end
            run_random_phase(148);
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("pid_controller_anti_windup_top_tb: clean");
        end else begin
            $display("pid_controller_anti_windup_top_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pidaw_pkg.sv
hdl/pid_controller_anti_windup_top.sv
hdl/pidaw_chk.sv
tb/pid_controller_anti_windup_top_tb.sv
